// ===== rtl/idiv_pkg.sv =====
// Shared constants and types for the radix-2 restoring integer divider.
// No dependencies; used by every other file of the divider.
package idiv_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(WORD_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  localparam logic MODE_UNSIGNED = 1'b0;
  localparam logic MODE_SIGNED   = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t rem;
    word_t quo;
    word_t num;
  } work_t;

  function automatic word_t neg_word(input word_t v);
    neg_word = word_t'(~v + word_t'(1));
  endfunction

endpackage

// ===== rtl/idiv_in_if.sv =====
// Request channel of the divider: mode bit, dividend and divisor words.
// Depends on idiv_pkg.
interface idiv_in_if;
  logic                 valid;
  logic                 ready;
  logic                 action;
  idiv_pkg::word_t      dividend;
  idiv_pkg::word_t      divisor;

  modport source (output valid, output action, output dividend, output divisor,
                  input ready);
  modport sink   (input valid, input action, input dividend, input divisor,
                  output ready);
endinterface

// ===== rtl/idiv_out_if.sv =====
// Response channel of the divider: quotient and remainder words.
// Depends on idiv_pkg.
interface idiv_out_if;
  logic                 valid;
  logic                 ready;
  idiv_pkg::word_t      quotient;
  idiv_pkg::word_t      remainder;

  modport source (output valid, output quotient, output remainder, input ready);
  modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

// ===== rtl/int_divider_signed_unsigned.sv =====
// Radix-2 restoring integer divider, signed or unsigned per request.
// Sequence from request accept to response valid: operands load at the accept,
// 32 steps run through the shared step unit, then 1 sign fix-up.
// Request ready is high only while idle; a finished response waits in the output register.
// Reset (rst, synchronous, active high) returns the sequencer to idle and drops valid.
// Depends on idiv_pkg, idiv_in_if, idiv_out_if and idiv_step.
module int_divider_signed_unsigned (
  input  logic       clk,
  input  logic       rst,
  idiv_in_if.sink    req,
  idiv_out_if.source rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [idiv_pkg::CNT_W-1:0]  cnt;
  idiv_pkg::work_t             work;
  idiv_pkg::work_t             step_nxt;
  idiv_pkg::word_t             den;
  logic                        dz;
  logic                        qneg;
  logic                        rneg;
  logic                        out_valid;
  logic                        out_valid_next;
  idiv_pkg::word_t             quotient;
  idiv_pkg::word_t             remainder;
  idiv_pkg::word_t             na;
  idiv_pkg::word_t             da;
  logic                        nneg;
  logic                        dneg;
  logic                        accept;
  logic                        load_out;

  idiv_step u_step (
    .cur (work),
    .den (den),
    .nxt (step_nxt)
  );

  assign accept   = req.valid && req.ready;
  assign load_out = (state == ST_FIX) && (!out_valid || rsp.ready);
  assign nneg     = (req.action == idiv_pkg::MODE_SIGNED) && req.dividend[idiv_pkg::WORD_BITS-1];
  assign dneg     = (req.action == idiv_pkg::MODE_SIGNED) && req.divisor[idiv_pkg::WORD_BITS-1];
  assign na       = nneg ? idiv_pkg::neg_word(req.dividend) : req.dividend;
  assign da       = dneg ? idiv_pkg::neg_word(req.divisor) : req.divisor;

  assign req.ready     = (state == ST_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.quotient  = quotient;
  assign rsp.remainder = remainder;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (cnt == idiv_pkg::CNT_LAST) state_next = ST_FIX;
      end
      ST_FIX: begin
        if (load_out) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work.rem <= '0;
      work.quo <= '0;
      work.num <= na;
      den      <= da;
      dz       <= (da == '0);
      qneg     <= nneg ^ dneg;
      rneg     <= nneg;
      cnt      <= '0;
    end else if (state == ST_RUN) begin
      work <= step_nxt;
      cnt  <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      quotient  <= dz ? '0 : (qneg ? idiv_pkg::neg_word(work.quo) : work.quo);
      remainder <= rneg ? idiv_pkg::neg_word(work.rem) : work.rem;
    end
  end

endmodule

// ===== rtl/idiv_step.sv =====
// Shared shift-compare-subtract unit: one restoring division step per use.
// Depends on idiv_pkg.
module idiv_step (
  input  idiv_pkg::work_t cur,
  input  idiv_pkg::word_t den,
  output idiv_pkg::work_t nxt
);

  logic [idiv_pkg::WORD_BITS:0]   shifted;
  logic [idiv_pkg::WORD_BITS:0]   diff;
  logic                           take;

  always_comb begin
    shifted = {cur.rem, cur.num[idiv_pkg::WORD_BITS-1]};
    diff    = shifted - {1'b0, den};
    take    = !diff[idiv_pkg::WORD_BITS];
    nxt.rem = take ? diff[idiv_pkg::WORD_BITS-1:0] : shifted[idiv_pkg::WORD_BITS-1:0];
    nxt.quo = {cur.quo[idiv_pkg::WORD_BITS-2:0], take};
    nxt.num = {cur.num[idiv_pkg::WORD_BITS-2:0], 1'b0};
  end

endmodule

// ===== rtl/idiv_checker.sv =====
// Port-level checks for the divider handshakes and sequencing, bound to the top level.
// Depends on int_divider_signed_unsigned and its channel interfaces.
module idiv_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input idiv_pkg::word_t rsp_quotient,
  input idiv_pkg::word_t rsp_remainder
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quotient) && $stable(rsp_remainder))
    else $error("response word changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request ready high right after an accept");

  a_busy_two_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> ##1 !req_ready)
    else $error("divider idle too soon after an accept");

  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("response appeared without a division in progress");

endmodule

bind int_divider_signed_unsigned idiv_checker u_idiv_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_quotient  (rsp.quotient),
  .rsp_remainder (rsp.remainder)
);

// ===== verif/tb_top.sv =====
// Self-checking bench for the signed/unsigned restoring integer divider.
// Predicts quotient and remainder per request and compares each response word.
// Depends on idiv_pkg, idiv_in_if, idiv_out_if and int_divider_signed_unsigned.
module tb_top;
  import idiv_pkg::*;

  localparam int    LATENCY     = 34;
  localparam int    MAX_WAIT    = 10;
  localparam int    DRAIN_LIMIT = 4000;
  localparam word_t SIGN_WORD   = word_t'(1) << (WORD_BITS - 1);
  localparam word_t ALL_ONES    = '1;

  typedef struct {
    logic  action;
    word_t dividend;
    word_t divisor;
    word_t quotient;
    word_t remainder;
  } div_case_t;

  logic clk;
  logic rst;
  logic steady;
  int   errors;
  int   checked;
  int   signed_sent;
  int   unsigned_sent;
  int   zero_div_sent;

  div_case_t pending_divs[$];

  idiv_in_if  req_if ();
  idiv_out_if rsp_if ();

  int_divider_signed_unsigned dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #6000000;
    $display("timeout with %0d responses outstanding", pending_divs.size());
    $display("int_divider_signed_unsigned test failed");
    $finish;
  end

  function automatic div_case_t divide_words(logic action, word_t dividend, word_t divisor);
    div_case_t c;
    logic      num_neg;
    logic      den_neg;
    word_t     num_mag;
    word_t     den_mag;
    word_t     quo;
    word_t     rmd;
    c.action   = action;
    c.dividend = dividend;
    c.divisor  = divisor;
    num_neg = (action == MODE_SIGNED) && dividend[WORD_BITS-1];
    den_neg = (action == MODE_SIGNED) && divisor[WORD_BITS-1];
    num_mag = num_neg ? word_t'(-dividend) : dividend;
    den_mag = den_neg ? word_t'(-divisor) : divisor;
    if (den_mag == '0) begin
      quo = '0;
      rmd = num_mag;
    end else begin
      quo = num_mag / den_mag;
      rmd = num_mag % den_mag;
    end
    if (num_neg != den_neg) begin
      quo = word_t'(-quo);
    end
    if (num_neg) begin
      rmd = word_t'(-rmd);
    end
    c.quotient  = quo;
    c.remainder = rmd;
    return c;
  endfunction

  function automatic word_t pick_operand();
    word_t v;
    case ($urandom_range(0, 7))
      0: v = word_t'($urandom_range(0, 15));
      1: v = ~word_t'($urandom_range(0, 15));
      2: begin
        case ($urandom_range(0, 3))
          0: v = ALL_ONES;
          1: v = SIGN_WORD;
          2: v = ~SIGN_WORD;
          default: v = SIGN_WORD + word_t'(1);
        endcase
      end
      3: v = word_t'($urandom);
      default: begin
        v = word_t'($urandom) >> $urandom_range(0, WORD_BITS - 1);
        if ($urandom_range(0, 1) == 1) begin
          v = word_t'(-v);
        end
      end
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    errors++;
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  task automatic send_division(logic action, word_t dividend, word_t divisor);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.action   <= action;
    req_if.dividend <= dividend;
    req_if.divisor  <= divisor;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    pending_divs.push_back(divide_words(action, dividend, divisor));
    if (action == MODE_SIGNED) signed_sent++;
    else unsigned_sent++;
    if (divisor == '0) zero_div_sent++;
    @(negedge clk);
  endtask

  // Responses: draw a stall per word, hold ready until the word moves.
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    div_case_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_divs.size() == 0) begin
        errors++;
        $display("[%0t] response %h/%h with nothing outstanding", $realtime,
                 rsp_if.quotient, rsp_if.remainder);
      end else begin
        want = pending_divs.pop_front();
        checked++;
        if (rsp_if.quotient !== want.quotient) begin
          report_mismatch($sformatf("quotient (mode %0b, %h / %h)", want.action,
                                    want.dividend, want.divisor),
                          rsp_if.quotient, want.quotient);
        end
        if (rsp_if.remainder !== want.remainder) begin
          report_mismatch($sformatf("remainder (mode %0b, %h / %h)", want.action,
                                    want.dividend, want.divisor),
                          rsp_if.remainder, want.remainder);
        end
      end
    end
  end

  task automatic test_directed_cases();
    send_division(MODE_UNSIGNED, '0, word_t'(1));
    send_division(MODE_UNSIGNED, ALL_ONES, word_t'(1));
    send_division(MODE_UNSIGNED, ALL_ONES, ALL_ONES);
    send_division(MODE_UNSIGNED, word_t'(100), word_t'(7));
    send_division(MODE_UNSIGNED, word_t'(1), ALL_ONES);
    send_division(MODE_UNSIGNED, SIGN_WORD, word_t'(2));
    send_division(MODE_UNSIGNED, word_t'(7), '0);
    send_division(MODE_UNSIGNED, '0, '0);
    send_division(MODE_UNSIGNED, ALL_ONES, '0);
    send_division(MODE_UNSIGNED, ALL_ONES, SIGN_WORD);
    send_division(MODE_SIGNED, SIGN_WORD, ALL_ONES);
    send_division(MODE_SIGNED, SIGN_WORD, word_t'(1));
    send_division(MODE_SIGNED, SIGN_WORD, SIGN_WORD);
    send_division(MODE_SIGNED, word_t'(-7), word_t'(2));
    send_division(MODE_SIGNED, word_t'(7), word_t'(-2));
    send_division(MODE_SIGNED, word_t'(-7), word_t'(-2));
    send_division(MODE_SIGNED, ~SIGN_WORD, ALL_ONES);
    send_division(MODE_SIGNED, ~SIGN_WORD, SIGN_WORD);
    send_division(MODE_SIGNED, ALL_ONES, '0);
    send_division(MODE_SIGNED, SIGN_WORD, '0);
    send_division(MODE_SIGNED, word_t'(5), '0);
    send_division(MODE_SIGNED, '0, '0);
    send_division(MODE_SIGNED, word_t'(3), word_t'(-5));
  endtask

  task automatic test_random_mode(logic action, int count);
    word_t divisor;
    repeat (count) begin
      divisor = ($urandom_range(0, 31) == 0) ? '0 : pick_operand();
      send_division(action, pick_operand(), divisor);
    end
  endtask

  task automatic test_mixed_random(int count);
    word_t divisor;
    repeat (count) begin
      divisor = ($urandom_range(0, 31) == 0) ? '0 : pick_operand();
      send_division(logic'($urandom_range(0, 1)), pick_operand(), divisor);
    end
  endtask

  task automatic test_back_to_back(int count);
    steady = 1'b1;
    test_mixed_random(count);
    steady = 1'b0;
  endtask

  initial begin
    rst             = 1'b1;
    steady          = 1'b0;
    errors          = 0;
    checked         = 0;
    signed_sent     = 0;
    unsigned_sent   = 0;
    zero_div_sent   = 0;
    req_if.valid    = 1'b0;
    req_if.action   = MODE_UNSIGNED;
    req_if.dividend = '0;
    req_if.divisor  = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_cases();
    test_random_mode(MODE_UNSIGNED, 500);
    test_random_mode(MODE_SIGNED, 500);
    test_back_to_back(400);
    test_mixed_random(400);

    req_if.valid <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && pending_divs.size() != 0; w++) @(negedge clk);
    repeat (LATENCY + 6) @(negedge clk);
    while (pending_divs.size() != 0) begin
      div_case_t left;
      left = pending_divs.pop_front();
      errors++;
      $display("missing response for mode %0b, %h / %h", left.action, left.dividend,
               left.divisor);
    end

    $display("covered %0d unsigned and %0d signed divisions, %0d by zero; %0d responses checked",
             unsigned_sent, signed_sent, zero_div_sent, checked);
    $display("%0d mismatches", errors);
    if (errors == 0) begin
      $display("int_divider_signed_unsigned test passed");
    end else begin
      $display("int_divider_signed_unsigned test failed");
    end
    $finish;
  end

endmodule
